// ===== rtl/polar_to_cartesian_assert.svh =====
// Assertion macros shared by the polar to cartesian converter.
`ifndef POLAR_TO_CARTESIAN_ASSERT_SVH
`define POLAR_TO_CARTESIAN_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define P2C_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("p2c assertion failed");

// Next-cycle implication, checked outside reset.
`define P2C_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("p2c assertion failed");

`endif

// ===== rtl/p2c_pkg.sv =====
// Constants and tables for the polar to cartesian converter.
package p2c_pkg;

	localparam int ROTATION_STAGES_DEF = 20;
	localparam int SAMPLE_WIDTH_DEF    = 24;
	localparam int GUARD_BITS          = 16;
	localparam int ATAN_ENTRIES        = 32;
	localparam int ANGLE_W             = 32;
	// residual angle with one spare bit above the turn
	localparam int ZW                  = ANGLE_W + 1;

	// radians Q.19 to turns: round(2^40/pi), product bits 28..59 give the angle
	localparam logic [38:0] TURN_SCALE = 39'd349985421095;
	localparam int TURN_SPLIT          = 20;
	localparam int PROD_W              = 60;
	localparam int ANGLE_LSB           = 28;

	// 1/K as Q0.32
	localparam logic [31:0] INV_GAIN   = 32'h9B74EDA8;

	// atan(2^-i) in 2^32-per-turn units
	localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

endpackage

// ===== rtl/p2c_front.sv =====
// Front end: phase to turns, gain compensation and quadrant fold.
module p2c_front #(
	parameter int SAMPLE_WIDTH = p2c_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]                magnitude,
	input  logic signed [SAMPLE_WIDTH-1:0]                phase_radians,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic signed [SAMPLE_WIDTH+p2c_pkg::GUARD_BITS+2:0] x,
	output logic signed [p2c_pkg::ZW-1:0]                 z
);
	import p2c_pkg::*;

	localparam int XW    = SAMPLE_WIDTH + GUARD_BITS + 3;
	localparam int PLO_W = SAMPLE_WIDTH + TURN_SPLIT + 1;
	localparam int PHI_W = SAMPLE_WIDTH + (39 - TURN_SPLIT) + 1;
	localparam int GP_W  = SAMPLE_WIDTH + GUARD_BITS + 1;

	localparam logic [TURN_SPLIT-1:0]    TURN_LO = TURN_SCALE[TURN_SPLIT-1:0];
	localparam logic [38-TURN_SPLIT:0]   TURN_HI = TURN_SCALE[38:TURN_SPLIT];
	localparam logic [GUARD_BITS-1:0]    GAIN_LO = INV_GAIN[GUARD_BITS-1:0];
	localparam logic [31-GUARD_BITS:0]   GAIN_HI = INV_GAIN[31:GUARD_BITS];

	logic                     valid_s1, valid_s2;
	logic                     ready_s1, ready_s2;
	logic signed [PLO_W-1:0]  ph_lo_s1;
	logic signed [PHI_W-1:0]  ph_hi_s1;
	logic signed [GP_W-1:0]   mag_lo_s1, mag_hi_s1;
	logic signed [XW-1:0]     x_s2;
	logic signed [ZW-1:0]     z_s2;

	logic [PROD_W-1:0]        ang_sum;
	logic [ANGLE_W-1:0]       angle;
	logic                     fold;
	logic signed [XW-1:0]     x_gain;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// split each wide constant product into two narrow partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			ph_lo_s1  <= PLO_W'(phase_radians) * PLO_W'($signed({1'b0, TURN_LO}));
			ph_hi_s1  <= PHI_W'(phase_radians) * PHI_W'($signed({1'b0, TURN_HI}));
			mag_lo_s1 <= GP_W'(magnitude) * GP_W'($signed({1'b0, GAIN_LO}));
			mag_hi_s1 <= GP_W'(magnitude) * GP_W'($signed({1'b0, GAIN_HI}));
		end
	end

	always_comb begin
		ang_sum = PROD_W'(ph_lo_s1) + (PROD_W'(ph_hi_s1) << TURN_SPLIT)
			+ (PROD_W'(1) << (ANGLE_LSB - 1));
		angle   = ang_sum[ANGLE_LSB +: ANGLE_W];
		// second and third quarter: rotate by half a turn, negate the start vector
		fold    = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
		x_gain  = XW'(mag_hi_s1) + XW'(mag_lo_s1 >>> GUARD_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			x_s2 <= fold ? -x_gain : x_gain;
			z_s2 <= {angle[ANGLE_W-1] ^ fold, angle[ANGLE_W-1] ^ fold,
				angle[ANGLE_W-2:0]};
		end
	end

	assign out_valid = valid_s2;
	assign x         = x_s2;
	assign z         = z_s2;

endmodule

// ===== rtl/p2c_cell.sv =====
// One rotation cell: a single micro-rotation by atan(2^-STAGE).
module p2c_cell #(
	parameter int SAMPLE_WIDTH = p2c_pkg::SAMPLE_WIDTH_DEF,
	parameter int STAGE        = 0
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               in_valid,
	output logic                                               in_ready,
	input  logic signed [SAMPLE_WIDTH+p2c_pkg::GUARD_BITS+2:0] x_in,
	input  logic signed [SAMPLE_WIDTH+p2c_pkg::GUARD_BITS+2:0] y_in,
	input  logic signed [p2c_pkg::ZW-1:0]                      z_in,
	output logic                                               out_valid,
	input  logic                                               out_ready,
	output logic signed [SAMPLE_WIDTH+p2c_pkg::GUARD_BITS+2:0] x_out,
	output logic signed [SAMPLE_WIDTH+p2c_pkg::GUARD_BITS+2:0] y_out,
	output logic signed [p2c_pkg::ZW-1:0]                      z_out
);
	import p2c_pkg::*;

	localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 3;
	localparam logic signed [ZW-1:0] STEP = $signed({1'b0, ATAN_TURNS[STAGE]});

	logic                 valid_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [XW-1:0] dx, dy;
	logic                 up;

	assign in_ready = !valid_q || out_ready;
	assign dx       = y_in >>> STAGE;
	assign dy       = x_in >>> STAGE;
	// rotate positively when the residual angle is zero or above
	assign up       = !z_in[ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_q <= up ? x_in - dx : x_in + dx;
			y_q <= up ? y_in + dy : y_in - dy;
			z_q <= up ? z_in - STEP : z_in + STEP;
		end
	end

	assign out_valid = valid_q;
	assign x_out     = x_q;
	assign y_out     = y_q;
	assign z_out     = z_q;

endmodule

// ===== rtl/p2c_back.sv =====
// Back end: round off the guard bits, saturate and hold the result.
module p2c_back #(
	parameter int SAMPLE_WIDTH = p2c_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               in_valid,
	output logic                                               in_ready,
	input  logic signed [SAMPLE_WIDTH+p2c_pkg::GUARD_BITS+2:0] x,
	input  logic signed [SAMPLE_WIDTH+p2c_pkg::GUARD_BITS+2:0] y,
	output logic                                               out_valid,
	input  logic                                               out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]                     real_part,
	output logic signed [SAMPLE_WIDTH-1:0]                     imag_part
);
	import p2c_pkg::*;

	localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 3;
	localparam int RW = XW - GUARD_BITS;

	function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] t;
		logic signed [RW-1:0] r;
		logic [RW-SAMPLE_WIDTH:0] top;
		t   = v + (XW'(1) << (GUARD_BITS - 1));
		r   = t[XW-1:GUARD_BITS];
		top = r[RW-1:SAMPLE_WIDTH-1];
		if ((&top) || !(|top)) begin
			round_sat = r[SAMPLE_WIDTH-1:0];
		end else if (r[RW-1]) begin
			round_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			round_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	endfunction

	logic                          valid_q;
	logic signed [SAMPLE_WIDTH-1:0] real_q, imag_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			real_q <= round_sat(x);
			imag_q <= round_sat(y);
		end
	end

	assign out_valid = valid_q;
	assign real_part = real_q;
	assign imag_part = imag_q;

endmodule

// ===== rtl/polar_to_cartesian.sv =====
// Top level of the polar to cartesian converter (pipelined rotator).
// An input passes the front-end registers, the rotation cells and the output register in turn.
// Throughput: one bin per cycle while out_ready is high; every stage holds its own valid bit and fills bubbles.
// The depth is set by the row of rotation cells, one micro-rotation per cell.
// Reset: asynchronous, active low; clears every stage's valid bit, data is not reset.
`include "polar_to_cartesian_assert.svh"
module polar_to_cartesian #(
	parameter int ROTATION_STAGES = p2c_pkg::ROTATION_STAGES_DEF,
	parameter int SAMPLE_WIDTH    = p2c_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] magnitude,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_radians,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] real_part,
	output logic signed [SAMPLE_WIDTH-1:0] imag_part
);
	import p2c_pkg::*;

	localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 3;

	logic                 cv [ROTATION_STAGES+1];
	logic                 cr [ROTATION_STAGES+1];
	logic signed [XW-1:0] cx [ROTATION_STAGES+1];
	logic signed [XW-1:0] cy [ROTATION_STAGES+1];
	logic signed [ZW-1:0] cz [ROTATION_STAGES+1];

	p2c_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.magnitude    (magnitude),
		.phase_radians(phase_radians),
		.out_valid    (cv[0]),
		.out_ready    (cr[0]),
		.x            (cx[0]),
		.z            (cz[0])
	);

	// rotation starts on the real axis
	assign cy[0] = '0;

	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
		p2c_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.STAGE       (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[i]),
			.in_ready (cr[i]),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.out_valid(cv[i+1]),
			.out_ready(cr[i+1]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1]),
			.z_out    (cz[i+1])
		);
	end

	p2c_back #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv[ROTATION_STAGES]),
		.in_ready (cr[ROTATION_STAGES]),
		.x        (cx[ROTATION_STAGES]),
		.y        (cy[ROTATION_STAGES]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.real_part(real_part),
		.imag_part(imag_part)
	);

	// an empty or draining output stage lets the whole row advance
	`P2C_ASSERT_NOW(a_ready_chain, clk, arst_n, (out_ready || !out_valid), in_ready)
	`P2C_ASSERT_NEXT(a_last_to_out, clk, arst_n, (cv[ROTATION_STAGES] && cr[ROTATION_STAGES]), out_valid)
	`P2C_ASSERT_NOW(a_out_source, clk, arst_n, $rose(out_valid), $past(cv[ROTATION_STAGES]))

endmodule
